// ----- rtl/spwm_pkg.sv -----
// Shared constants, types and the quarter-wave sine table for the SPWM duty generator.
package spwm_pkg;

  localparam int PHASE_BITS = 16;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int HARMONIC_ORDER = 3;
  localparam int DUTY_BITS = 12;

  localparam int STEP_BITS = 16;
  localparam int AMP_BITS = 16;
  localparam int HSCALE_BITS = 15;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HSCALE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HENABLE = 2'd2;

  localparam logic [AMP_BITS-1:0] AMP_RESET = 16'd26214;
  localparam logic [HSCALE_BITS-1:0] HSCALE_RESET = 15'd5461;

  localparam int TABLE_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_BITS = 16;
  localparam int SINE_PEAK = 32767;
  localparam int SIG_BITS = 18;
  localparam int HPROD_BITS = 2 * (SINE_BITS - 1);
  localparam int P1_BITS = SIG_BITS - 1 + AMP_BITS;
  localparam int P2_BITS = P1_BITS + DUTY_BITS - 1;
  localparam int OFF_BITS = P2_BITS - 29;
  localparam int DUTY_SUM_BITS = OFF_BITS + 2;
  localparam int DUTY_MID = 2 ** (DUTY_BITS - 1);
  localparam int DUTY_MAX = 2 ** DUTY_BITS - 1;
  localparam int THIRD_TURN = (2 ** PHASE_BITS + 1) / 3;
  localparam int DIV_CNT_BITS = $clog2(PHASE_BITS + 1);
  localparam int OUT_DATA_BITS = ((3 * DUTY_BITS + 7) / 8) * 8;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam logic [7:0] TAYLOR_DIV [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

  typedef logic [SINE_BITS-1:0] sine_table_t [SINE_TABLE_DEPTH];

  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] v;
    logic signed [63:0] sum;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x = (PI_HALF_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      term = x;
      sum = signed'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((((term * x) >> 30) * x) >> 30) / 64'(TAYLOR_DIV[k-1]);
        if ((k % 2) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = (unsigned'(sum) * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
      if (v > 64'(SINE_PEAK)) begin
        v = 64'(SINE_PEAK);
      end
      tbl[i] = v[SINE_BITS-1:0];
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ----- rtl/spwm_div.sv -----
// Restoring divider, one quotient bit per cycle, for realigning the phase to its step slot.
module spwm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [spwm_pkg::PHASE_BITS-1:0] dividend,
  input  logic [spwm_pkg::STEP_BITS-1:0]  divisor,
  output logic                           done,
  output logic [spwm_pkg::PHASE_BITS-1:0] quotient
);
  import spwm_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] count;
  logic [STEP_BITS-1:0]    rem;
  logic [PHASE_BITS-1:0]   quo;
  logic [STEP_BITS:0]      trial;
  logic [STEP_BITS:0]      diff;
  logic                    fits;

  assign trial = {rem, quo[PHASE_BITS-1]};
  assign diff = trial - {1'b0, divisor};
  assign fits = trial >= {1'b0, divisor};
  assign done = busy && (count == '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= DIV_CNT_BITS'(PHASE_BITS);
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy && (count != '0)) begin
      rem <= fits ? diff[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
      quo <= {quo[PHASE_BITS-2:0], fits};
    end
  end

endmodule

// ----- rtl/spwm_sine.sv -----
// Quarter-wave sine ROM with quadrant folding and a registered read.
module spwm_sine (
  input  logic                                 clk,
  input  logic [spwm_pkg::PHASE_BITS-1:0]       angle,
  output logic signed [spwm_pkg::SINE_BITS-1:0] sine
);
  import spwm_pkg::*;

  logic [TABLE_BITS+1:0]  idx;
  logic [1:0]             quad;
  logic [TABLE_BITS-1:0]  r;
  logic [TABLE_BITS-1:0]  addr;
  logic                   peak;
  logic [SINE_BITS-1:0]   mag_rd;
  logic                   peak_rd;
  logic                   neg_rd;
  logic [SINE_BITS-1:0]   mag;

  assign idx = angle[PHASE_BITS-1 -: TABLE_BITS+2];
  assign quad = idx[TABLE_BITS+1:TABLE_BITS];
  assign r = idx[TABLE_BITS-1:0];
  assign addr = quad[0] ? (~r + 1'b1) : r;
  assign peak = quad[0] && (r == '0);

  always_ff @(posedge clk) begin
    mag_rd <= SINE_TABLE[addr];
    peak_rd <= peak;
    neg_rd <= quad[1];
  end

  assign mag = peak_rd ? SINE_BITS'(SINE_PEAK) : mag_rd;
  assign sine = neg_rd ? -signed'(mag) : signed'(mag);

endmodule

// ----- rtl/three_phase_spwm_duty_generator.sv -----
// Top level: phase accumulator, per-phase sequencer, duty scaling and output register.
// Requests are taken only in the idle state, so a new request waits until the last result
// has gone to the output register; each phase takes seven steps through the single sine ROM
// port, and a request that realigns a nonzero phase first runs a 16-step serial divide.
// A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous): phase 0, registers to their defaults, output empty.
module three_phase_spwm_duty_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [spwm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [spwm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [spwm_pkg::STEP_BITS-1:0]         s_tdata,  // [15:0] phase_step
  input  logic                                  s_tuser,  // [0] freq_change
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [spwm_pkg::OUT_DATA_BITS-1:0]     m_tdata   // duty_u, duty_v, duty_w, pad
);
  import spwm_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV   = 4'd1;
  localparam logic [3:0] ST_SIN   = 4'd2;
  localparam logic [3:0] ST_FUND  = 4'd3;
  localparam logic [3:0] ST_HARM  = 4'd4;
  localparam logic [3:0] ST_SUM   = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_SCALE = 4'd7;
  localparam logic [3:0] ST_DUTY  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic [PHASE_BITS-1:0] THIRD = PHASE_BITS'(THIRD_TURN);

  logic [3:0]                     state;
  logic [1:0]                     k;
  logic [AMP_BITS-1:0]            amplitude;
  logic [HSCALE_BITS-1:0]         hscale;
  logic                           henable;
  logic [PHASE_BITS-1:0]          phase;
  logic [STEP_BITS-1:0]           step;

  logic                           accept;
  logic                           need_div;
  logic [PHASE_BITS-1:0]          phase_next;
  logic [PHASE_BITS+STEP_BITS:0]  sum_wide;
  logic [PHASE_BITS+STEP_BITS:0]  snap_wide;

  logic                           div_start;
  logic                           div_done;
  logic [PHASE_BITS-1:0]          div_q;

  logic [PHASE_BITS-1:0]          angle;
  logic [PHASE_BITS+3:0]          harm_full;
  logic [PHASE_BITS-1:0]          rom_angle;
  logic signed [SINE_BITS-1:0]    sine;

  logic signed [SINE_BITS-1:0]    fund;
  logic [HPROD_BITS-1:0]          hprod;
  logic                           hneg;
  logic [HPROD_BITS:0]            hround;
  logic signed [SIG_BITS-1:0]     hterm;
  logic signed [SIG_BITS-1:0]     sig;
  logic [SIG_BITS-1:0]            sig_abs;
  logic [SINE_BITS-1:0]           hmag;
  logic [P1_BITS-1:0]             prod1;
  logic [P2_BITS-1:0]             prod2;
  logic                           sneg;
  logic [P2_BITS:0]               rsum;
  logic [OFF_BITS-1:0]            off;
  logic signed [DUTY_SUM_BITS-1:0] dsum;
  logic [DUTY_BITS-1:0]           dsat;
  logic [DUTY_BITS-1:0]           duty_work [3];

  spwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (phase),
    .divisor  (step),
    .done     (div_done),
    .quotient (div_q)
  );

  spwm_sine u_sine (
    .clk   (clk),
    .angle (rom_angle),
    .sine  (sine)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;

  always_comb begin
    sum_wide = (PHASE_BITS+STEP_BITS+1)'(phase) + (PHASE_BITS+STEP_BITS+1)'(s_tdata);
    need_div = 1'b0;
    if (phase == '0) begin
      phase_next = PHASE_BITS'(s_tdata >> 1);
    end else if (!s_tuser) begin
      phase_next = sum_wide[PHASE_BITS-1:0];
    end else if (s_tdata == '0) begin
      phase_next = phase;
    end else begin
      phase_next = phase;
      need_div = 1'b1;
    end
  end

  assign div_start = accept && need_div;
  assign snap_wide = (PHASE_BITS+STEP_BITS+1)'(div_q) * (PHASE_BITS+STEP_BITS+1)'(step)
                   + (PHASE_BITS+STEP_BITS+1)'(step >> 1);

  always_comb begin
    case (k)
      2'd1:    angle = phase - THIRD;
      2'd2:    angle = phase + THIRD;
      default: angle = phase;
    endcase
  end

  assign harm_full = (PHASE_BITS+4)'(angle) * (PHASE_BITS+4)'(HARMONIC_ORDER);
  assign rom_angle = (state == ST_FUND) ? harm_full[PHASE_BITS-1:0] : angle;

  assign hmag = sine[SINE_BITS-1] ? SINE_BITS'(-sine) : SINE_BITS'(sine);
  assign hround = (HPROD_BITS+1)'(hprod) + (HPROD_BITS+1)'(16384);
  assign hterm = hneg ? -SIG_BITS'(hround[HPROD_BITS:15]) : SIG_BITS'(hround[HPROD_BITS:15]);
  assign sig_abs = sig[SIG_BITS-1] ? SIG_BITS'(-sig) : SIG_BITS'(sig);

  assign rsum = (P2_BITS+1)'(prod2) + (P2_BITS+1)'(64'd1 << 29);
  assign off = rsum[P2_BITS:30];

  always_comb begin
    if (sneg) begin
      dsum = DUTY_SUM_BITS'(DUTY_MID) - signed'(DUTY_SUM_BITS'(off));
    end else begin
      dsum = DUTY_SUM_BITS'(DUTY_MID) + signed'(DUTY_SUM_BITS'(off));
    end
    if (dsum < 0) begin
      dsat = '0;
    end else if (dsum > DUTY_SUM_BITS'(DUTY_MAX)) begin
      dsat = DUTY_BITS'(DUTY_MAX);
    end else begin
      dsat = dsum[DUTY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_RESET;
      hscale <= HSCALE_RESET;
      henable <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_AMPLITUDE: amplitude <= cfg_data[AMP_BITS-1:0];
        CFG_HSCALE:    hscale <= cfg_data[HSCALE_BITS-1:0];
        CFG_HENABLE:   henable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= 2'd0;
      phase <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase <= phase_next;
            k <= 2'd0;
            state <= need_div ? ST_DIV : ST_SIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            phase <= snap_wide[PHASE_BITS-1:0];
            state <= ST_SIN;
          end
        end
        ST_SIN:   state <= ST_FUND;
        ST_FUND:  state <= ST_HARM;
        ST_HARM:  state <= ST_SUM;
        ST_SUM:   state <= ST_MUL;
        ST_MUL:   state <= ST_SCALE;
        ST_SCALE: state <= ST_DUTY;
        ST_DUTY: begin
          if (k == 2'd2) begin
            state <= ST_OUT;
          end else begin
            k <= k + 2'd1;
            state <= ST_SIN;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step <= s_tdata;
    end
    case (state)
      ST_FUND: fund <= sine;
      ST_HARM: begin
        hprod <= HPROD_BITS'(hmag) * HPROD_BITS'(hscale);
        hneg <= sine[SINE_BITS-1];
      end
      ST_SUM: sig <= SIG_BITS'(fund) + (henable ? hterm : SIG_BITS'(0));
      ST_MUL: begin
        prod1 <= P1_BITS'(sig_abs[SIG_BITS-2:0]) * P1_BITS'(amplitude);
        sneg <= sig[SIG_BITS-1];
      end
      ST_SCALE: prod2 <= P2_BITS'(prod1) * P2_BITS'(DUTY_MID - 1);
      ST_DUTY:  duty_work[k] <= dsat;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= OUT_DATA_BITS'({duty_work[2], duty_work[1], duty_work[0]});
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- dv/tb_three_phase_spwm_duty_generator.sv -----
// Self-checking testbench for the three-phase SPWM duty generator.
module tb_three_phase_spwm_duty_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [spwm_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam int LATENCY_PAUSE = 40;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    bit [11:0] u;
    bit [11:0] v;
    bit [11:0] w;
  } duty_triplet_t;

  class duty_scoreboard;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int PEAK = 32767;
    localparam int ONE_THIRD = 21845;
    localparam longint DUTY_CENTER = 2048;
    localparam longint DUTY_TOP = 4095;

    bit [15:0] amplitude;
    bit [14:0] harmonic_gain;
    bit harmonic_on;
    bit [15:0] angle;
    bit [15:0] quarter_sine [256];
    duty_triplet_t pending_duties [$];
    int mismatches;

    function new();
      longint unsigned x;
      longint unsigned term;
      longint unsigned v;
      longint sum;
      amplitude = 16'd26214;
      harmonic_gain = 15'd5461;
      harmonic_on = 1'b0;
      angle = 16'd0;
      mismatches = 0;
      for (int i = 0; i < 256; i++) begin
        x = (HALF_PI_Q30 * longint'(i)) / 64'd256;
        term = x;
        sum = longint'(x);
        for (int unsigned k = 1; k <= 7; k++) begin
          term = ((((term * x) >> 30) * x) >> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
          v = 64'd32767;
        end
        quarter_sine[i] = v[15:0];
      end
    endfunction

    function void write_reg(bit [1:0] idx, bit [15:0] data);
      case (idx)
        spwm_pkg::CFG_AMPLITUDE: amplitude = data;
        spwm_pkg::CFG_HSCALE: harmonic_gain = data[14:0];
        spwm_pkg::CFG_HENABLE: harmonic_on = data[0];
        default: ;
      endcase
    endfunction

    function int sine_at(bit [15:0] p);
      bit [9:0] idx;
      bit [1:0] quad;
      bit [7:0] r;
      int mag;
      idx = p[15:6];
      quad = idx[9:8];
      r = idx[7:0];
      if (quad[0]) begin
        mag = (r == 0) ? PEAK : int'(quarter_sine[256 - int'(r)]);
      end else begin
        mag = int'(quarter_sine[r]);
      end
      return quad[1] ? -mag : mag;
    endfunction

    function int scale_q15(int a, int unsigned b);
      longint unsigned m;
      m = longint'((a < 0) ? -a : a);
      m = (m * b + 64'd16384) >> 15;
      return (a < 0) ? -int'(m) : int'(m);
    endfunction

    function int signal_at(bit [15:0] p);
      int s;
      s = sine_at(p);
      if (harmonic_on) begin
        s += scale_q15(sine_at(16'(p * 3)), harmonic_gain);
      end
      return s;
    endfunction

    function bit [11:0] duty_of(int s);
      longint unsigned mag;
      longint unsigned off;
      longint d;
      mag = longint'((s < 0) ? -s : s);
      off = (mag * amplitude * 64'd2047 + (64'd1 << 29)) >> 30;
      d = (s < 0) ? DUTY_CENTER - longint'(off) : DUTY_CENTER + longint'(off);
      if (d < 0) begin
        d = 0;
      end
      if (d > DUTY_TOP) begin
        d = DUTY_TOP;
      end
      return d[11:0];
    endfunction

    function void note_request(bit [15:0] step, bit snap);
      bit [31:0] p;
      duty_triplet_t want;
      p = angle;
      if (p == 0) begin
        p = step >> 1;
      end else if (!snap) begin
        p = p + step;
      end else if (step != 0) begin
        p = (p / step) * step + (step >> 1);
      end
      angle = p[15:0];
      want.u = duty_of(signal_at(angle));
      want.v = duty_of(signal_at(16'(angle - ONE_THIRD)));
      want.w = duty_of(signal_at(16'(angle + ONE_THIRD)));
      pending_duties.push_back(want);
    endfunction

    function void check_duty(bit [11:0] u, bit [11:0] v, bit [11:0] w);
      duty_triplet_t want;
      if (pending_duties.size() == 0) begin
        $error("duty result with no request pending: u %0d v %0d w %0d", u, v, w);
        mismatches++;
        return;
      end
      want = pending_duties.pop_front();
      if (u != want.u) begin
        $error("duty_u: expected %0d, actual %0d", want.u, u);
        mismatches++;
      end
      if (v != want.v) begin
        $error("duty_v: expected %0d, actual %0d", want.v, v);
        mismatches++;
      end
      if (w != want.w) begin
        $error("duty_w: expected %0d, actual %0d", want.w, w);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_duties.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [spwm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [spwm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [spwm_pkg::STEP_BITS-1:0] s_tdata = '0;  // [15:0] phase_step
  logic s_tuser = 1'b0;  // [0] freq_change
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [spwm_pkg::OUT_DATA_BITS-1:0] m_tdata;  // [11:0] duty_u, [23:12] duty_v, [35:24] duty_w

  duty_scoreboard duties;
  int idle_cycles = 0;
  int ready_left = 0;
  bit ready_now;

  three_phase_spwm_duty_generator dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      duties.note_request(s_tdata, s_tuser);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      duties.check_duty(m_tdata[11:0], m_tdata[23:12], m_tdata[35:24]);
    end
  end

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_now = ($urandom_range(0, 99) < 60);
      ready_left = ready_now ? $urandom_range(1, 40) : $urandom_range(1, 30);
      m_tready <= ready_now;
    end else begin
      ready_left--;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_three_phase_spwm_duty_generator failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    duties.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input int unsigned amp, input int unsigned gain, input bit on);
    write_reg(spwm_pkg::CFG_AMPLITUDE, 16'(amp));
    write_reg(spwm_pkg::CFG_HSCALE, {1'($urandom), 15'(gain)});
    write_reg(spwm_pkg::CFG_HENABLE, {15'($urandom), on});
  endtask

  task automatic send_request(input logic [15:0] step, input logic snap);
    s_tvalid <= 1'b1;
    s_tdata <= step;
    s_tuser <= snap;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic settle_outputs();
    s_tvalid <= 1'b0;
    while (duties.pending() != 0) @(negedge clk);
    repeat (LATENCY_PAUSE) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int sent;
    int burst;
    int roll;
    logic [15:0] run_step;
    logic [15:0] step;
    logic snap;
    sent = 0;
    run_step = 16'($urandom_range(1, 2048));
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < count; b++) begin
        roll = $urandom_range(0, 99);
        snap = 1'b0;
        if (roll < 8) begin
          run_step = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 32768))
                                                 : 16'($urandom_range(1, 512));
          snap = 1'b1;
        end else if (roll < 12) begin
          snap = 1'b1;
        end
        step = run_step;
        if (roll >= 92) begin
          step = 16'($urandom);
          snap = 1'($urandom);
        end else if (roll >= 90) begin
          step = 16'd0;
        end
        send_request(step, snap);
        sent++;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
    end
  endtask

  initial begin
    duties = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_config(32768, 32767, 1'b1);
    send_request(16'd0, 1'b0);
    send_request(16'd0, 1'b1);
    send_request(16'd1, 1'b0);
    send_request(16'd3, 1'b0);
    send_request(16'd0, 1'b1);
    send_request(16'd0, 1'b0);
    pause_sender(3);
    send_request(16'd32768, 1'b0);
    send_request(16'd65535, 1'b0);
    send_request(16'd1000, 1'b1);
    send_request(16'd65535, 1'b1);
    send_request(16'd32767, 1'b0);
    send_request(16'd2, 1'b0);
    send_request(16'd4000, 1'b1);
    repeat (4) send_request(16'd16384, 1'b0);
    repeat (3) send_request(16'd21845, 1'b0);
    send_request(16'd1, 1'b1);
    send_request(16'hAAAA, 1'b1);
    send_request(16'h5555, 1'b0);
    settle_outputs();

    set_config(26214, 5461, 1'b0);
    run_random(130);
    settle_outputs();

    set_config(0, 0, 1'b1);
    run_random(100);
    settle_outputs();

    set_config(65535, 5461, 1'b1);
    run_random(120);
    settle_outputs();

    set_config(32768, 32767, 1'b0);
    write_reg(CFG_SPARE, 16'($urandom));
    run_random(120);
    settle_outputs();

    repeat (3) begin
      set_config($urandom_range(0, 32768), $urandom_range(0, 32767), 1'($urandom));
      run_random(110);
      settle_outputs();
    end

    if (duties.mismatches == 0 && duties.pending() == 0) begin
      $display("tb_three_phase_spwm_duty_generator passed");
    end else begin
      $display("tb_three_phase_spwm_duty_generator failed");
    end
    $finish;
  end

endmodule
